// ===== rtl/ccb_pkg.sv =====
// Shared types, constants and helpers for the clock chime beeper.
package ccb_pkg;

	localparam int unsigned CFG_W   = 16;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned MIN_W   = 6;
	localparam int unsigned SEC_W   = 6;
	localparam int unsigned BEEPS_W = 4;

	localparam logic [CFG_W-1:0] TONE_RESET   = 16'd700;
	localparam logic [CFG_W-1:0] GAP_RESET    = 16'd300;
	localparam logic [CFG_W-1:0] BUTTON_RESET = 16'd120;

	localparam logic [HOUR_W-1:0] NO_HOUR     = 5'd31;
	localparam logic [HOUR_W-1:0] DIAL_HOURS  = 5'd12;
	localparam logic [MIN_W-1:0]  HALF_MINUTE = 6'd30;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_BUTTON  = 2'd1,
		CMD_SILENCE = 2'd2
	} ccb_cmd_t;

	typedef enum logic [1:0] {
		REG_TONE   = 2'd0,
		REG_GAP    = 2'd1,
		REG_BUTTON = 2'd2
	} ccb_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0] tone_length_ms;
		logic [CFG_W-1:0] gap_length_ms;
		logic [CFG_W-1:0] button_beep_ms;
	} ccb_cfg_t;

	typedef struct packed {
		ccb_cmd_t            command;
		logic [TIME_W-1:0]   now_ms;
		logic [HOUR_W-1:0]   hour;
		logic [MIN_W-1:0]    minute;
		logic [SEC_W-1:0]    second;
	} ccb_item_t;

	typedef struct packed {
		logic               button_beeping;
		logic               chime_active;
		logic               tone_phase;
		logic [BEEPS_W-1:0] beeps_left;
		logic               pin_level;
	} ccb_status_t;

	// Hour to strike count on a 12-hour dial; zero reads as twelve.
	function automatic logic [BEEPS_W-1:0] hour_to_dial(input logic [HOUR_W-1:0] hr);
		logic [HOUR_W-1:0] r;
		begin
			if (hr >= HOUR_W'(2 * DIAL_HOURS)) begin
				r = hr - HOUR_W'(2 * DIAL_HOURS);
			end else if (hr >= DIAL_HOURS) begin
				r = hr - DIAL_HOURS;
			end else begin
				r = hr;
			end
			if (r == '0) begin
				r = DIAL_HOURS;
			end
			return r[BEEPS_W-1:0];
		end
	endfunction

endpackage

// ===== rtl/ccb_regs.sv =====
// Configuration registers of the clock chime beeper.
module ccb_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output ccb_pkg::ccb_cfg_t   cfg
);
	import ccb_pkg::*;

	ccb_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tone_length_ms <= TONE_RESET;
			cfg_q.gap_length_ms  <= GAP_RESET;
			cfg_q.button_beep_ms <= BUTTON_RESET;
		end else if (cfg_write) begin
			case (ccb_reg_t'(cfg_index))
				REG_TONE:   cfg_q.tone_length_ms <= cfg_data;
				REG_GAP:    cfg_q.gap_length_ms  <= cfg_data;
				REG_BUTTON: cfg_q.button_beep_ms <= cfg_data;
				default:    ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/ccb_core.sv =====
// Chime and button beep state with its next-state logic.
module ccb_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  ccb_pkg::ccb_item_t    item,
	input  ccb_pkg::ccb_cfg_t     cfg,
	output logic                  level_next,
	output ccb_pkg::ccb_status_t  status
);
	import ccb_pkg::*;

	ccb_status_t        st_q, st_n;
	logic [TIME_W-1:0]  last_toggle_q, last_toggle_n;
	logic [HOUR_W-1:0]  last_hour_q, last_hour_n;
	logic [HOUR_W-1:0]  last_half_q, last_half_n;
	logic [TIME_W-1:0]  elapsed;
	logic [BEEPS_W-1:0] beeps_dec;

	always_comb begin
		st_n          = st_q;
		last_toggle_n = last_toggle_q;
		last_hour_n   = last_hour_q;
		last_half_n   = last_half_q;
		elapsed       = item.now_ms - last_toggle_q;
		beeps_dec     = '0;
		case (item.command)
			CMD_TICK: begin
				if (st_q.button_beeping) begin
					if (elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.button_beep_ms}) begin
						st_n.pin_level      = 1'b0;
						st_n.button_beeping = 1'b0;
					end
				end else begin
					if (item.minute == '0 && item.second == '0 && item.hour != last_hour_q) begin
						last_hour_n       = item.hour;
						st_n.beeps_left   = hour_to_dial(item.hour);
						st_n.chime_active = 1'b1;
						st_n.tone_phase   = 1'b0;
					end
					if (item.minute == HALF_MINUTE && item.second == '0
						&& item.hour != last_half_q) begin
						last_half_n       = item.hour;
						st_n.beeps_left   = BEEPS_W'(1);
						st_n.chime_active = 1'b1;
						st_n.tone_phase   = 1'b0;
					end
					if (st_n.chime_active) begin
						if (!st_n.tone_phase
							&& elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.gap_length_ms}) begin
							st_n.pin_level  = 1'b1;
							st_n.tone_phase = 1'b1;
							last_toggle_n   = item.now_ms;
						end else if (st_n.tone_phase
							&& elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.tone_length_ms}) begin
							st_n.pin_level  = 1'b0;
							st_n.tone_phase = 1'b0;
							last_toggle_n   = item.now_ms;
							beeps_dec       = (st_n.beeps_left != '0) ?
								st_n.beeps_left - BEEPS_W'(1) : '0;
							st_n.beeps_left = beeps_dec;
							if (beeps_dec == '0) begin
								st_n.chime_active = 1'b0;
							end
						end
					end
				end
			end
			CMD_BUTTON: begin
				st_n.pin_level      = 1'b1;
				st_n.button_beeping = 1'b1;
				last_toggle_n       = item.now_ms;
			end
			CMD_SILENCE: begin
				st_n.button_beeping = 1'b0;
				st_n.beeps_left     = '0;
				st_n.tone_phase     = 1'b0;
				st_n.chime_active   = 1'b0;
				st_n.pin_level      = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= '0;
			last_toggle_q <= '0;
			last_hour_q   <= NO_HOUR;
			last_half_q   <= NO_HOUR;
		end else if (fire) begin
			st_q          <= st_n;
			last_toggle_q <= last_toggle_n;
			last_hour_q   <= last_hour_n;
			last_half_q   <= last_half_n;
		end
	end

	assign level_next = st_n.pin_level;
	assign status     = st_q;

endmodule

// ===== rtl/clock_chime_beeper_unit.sv =====
// Top level of the clock chime beeper: input register, core and result register.
//
//  channel  direction  handshake              payload
//  in       request    in_valid / in_ready    command, now_ms, hour, minute, second
//  out      result     out_valid / out_ready  buzzer_on
//  cfg      write      cfg_write              cfg_index, cfg_data
//
// One request per cycle while out_ready holds; input register, then result register.
// The state update and the result register load happen in the same cycle, so each
// request sees the state left by the one before it.
// Reset empties the pipeline and idles the core; registers return to 700, 300, 120 ms.
// A stalled result holds the input register, which still frees when the result leaves.
module clock_chime_beeper_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [31:0] now_ms,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [5:0]  second,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        buzzer_on,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import ccb_pkg::*;

	logic        valid_s1;
	ccb_item_t   item_s1;
	logic        valid_s2;
	logic        buzzer_s2;
	logic        s2_free;
	logic        fire;
	logic        level_next;
	ccb_cfg_t    cfg;
	ccb_status_t status;

	assign s2_free  = !valid_s2 || out_ready;
	assign fire     = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.command <= ccb_cmd_t'(command);
			item_s1.now_ms  <= now_ms;
			item_s1.hour    <= hour;
			item_s1.minute  <= minute;
			item_s1.second  <= second;
		end
	end

	ccb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ccb_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.cfg        (cfg),
		.level_next (level_next),
		.status     (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			buzzer_s2 <= level_next;
		end
	end

	assign out_valid = valid_s2;
	assign buzzer_on = buzzer_s2;

	a_chime_has_beeps: assert property (@(posedge clk) disable iff (!arst_n)
		status.chime_active |-> status.beeps_left != '0)
		else $error("chime active with no beeps left");

	a_button_sounds: assert property (@(posedge clk) disable iff (!arst_n)
		status.button_beeping |-> status.pin_level)
		else $error("button beep running with buzzer off");

	a_silence_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.command == CMD_SILENCE) |=>
			(!status.pin_level && !status.chime_active && !buzzer_on))
		else $error("silence left the buzzer or chime on");

	a_result_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (out_valid && buzzer_on == status.pin_level))
		else $error("result register disagrees with state");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s2_free) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost a stalled request");

endmodule

// ===== tb/sv/tb_clock_chime_beeper_unit.sv =====
// Self-checking testbench for clock_chime_beeper_unit: directed and random commands.
module tb_clock_chime_beeper_unit;
	import ccb_pkg::*;

	localparam int unsigned LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 64;
	localparam logic [1:0] CMD_IGNORED = 2'd3;
	localparam logic [1:0] REG_NONE = 2'd3;

	typedef struct {
		logic [1:0]  cmd;
		logic [31:0] ms;
		logic [4:0]  hr;
		logic [5:0]  mn;
		logic [5:0]  sc;
	} chime_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  command = '0;
	logic [31:0] now_ms = '0;
	logic [4:0]  hour = '0;
	logic [5:0]  minute = '0;
	logic [5:0]  second = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        buzzer_on;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	clock_chime_beeper_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .now_ms(now_ms), .hour(hour), .minute(minute), .second(second),
		.out_valid(out_valid), .out_ready(out_ready), .buzzer_on(buzzer_on),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [15:0] tone_ms = TONE_RESET;
	logic [15:0] gap_ms = GAP_RESET;
	logic [15:0] button_ms = BUTTON_RESET;
	logic        btn_beeping = 1'b0;
	logic        chime_on = 1'b0;
	logic        in_tone = 1'b0;
	logic [3:0]  beeps_rem = '0;
	logic [31:0] mark_ms = '0;
	logic [4:0]  hour_mark = NO_HOUR;
	logic [4:0]  half_mark = NO_HOUR;
	logic        buzz = 1'b0;

	chime_req_t  pending_q[$];
	logic        buzz_q[$];
	chime_req_t  nxt;
	logic        req_taken = 1'b0;
	logic        steady = 1'b0;
	logic        hold_req = 1'b0;
	int unsigned hold_cnt = 0;
	int unsigned cyc = 0;
	int unsigned errors = 0;
	int unsigned queued_n = 0;
	int unsigned accepted_n = 0;
	int unsigned results_n = 0;
	int unsigned tones_n = 0;
	int unsigned presses_n = 0;
	logic [31:0] tb_ms;
	logic [4:0]  cur_hr;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic chime_step(input logic [1:0] cmd, input logic [31:0] ms,
			input logic [4:0] hr, input logic [5:0] mn, input logic [5:0] sc);
		logic [31:0] elapsed;
		logic [4:0]  dial;
		elapsed = ms - mark_ms;
		case (cmd)
			CMD_TICK: begin
				if (btn_beeping) begin
					if (elapsed > {16'd0, button_ms}) begin
						buzz = 1'b0;
						btn_beeping = 1'b0;
					end
				end else begin
					if (mn == '0 && sc == '0 && hr != hour_mark) begin
						hour_mark = hr;
						dial = hr % DIAL_HOURS;
						if (dial == '0) begin
							dial = DIAL_HOURS;
						end
						beeps_rem = dial[3:0];
						chime_on = 1'b1;
						in_tone = 1'b0;
					end
					if (mn == HALF_MINUTE && sc == '0 && hr != half_mark) begin
						half_mark = hr;
						beeps_rem = 4'd1;
						chime_on = 1'b1;
						in_tone = 1'b0;
					end
					if (chime_on) begin
						if (!in_tone && elapsed >= {16'd0, gap_ms}) begin
							buzz = 1'b1;
							in_tone = 1'b1;
							mark_ms = ms;
							tones_n++;
						end else if (in_tone && elapsed >= {16'd0, tone_ms}) begin
							buzz = 1'b0;
							in_tone = 1'b0;
							mark_ms = ms;
							if (beeps_rem != '0) begin
								beeps_rem--;
							end
							if (beeps_rem == '0) begin
								chime_on = 1'b0;
							end
						end
					end
				end
			end
			CMD_BUTTON: begin
				buzz = 1'b1;
				btn_beeping = 1'b1;
				mark_ms = ms;
				presses_n++;
			end
			CMD_SILENCE: begin
				btn_beeping = 1'b0;
				beeps_rem = '0;
				in_tone = 1'b0;
				chime_on = 1'b0;
				buzz = 1'b0;
			end
			default: begin
			end
		endcase
		return buzz;
	endfunction

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || req_taken)) begin
			req_taken = 1'b0;
			if (pending_q.size() != 0 && (steady || $urandom_range(0, 99) >= 29)) begin
				nxt = pending_q.pop_front();
				in_valid <= 1'b1;
				command <= nxt.cmd;
				now_ms <= nxt.ms;
				hour <= nxt.hr;
				minute <= nxt.mn;
				second <= nxt.sc;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || $urandom_range(0, 99) >= 29;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		cyc++;
		if (cyc >= LIMIT) begin
			$display("%0t timeout after %0d cycles", $time, cyc);
			$display("clock_chime_beeper_unit verification failed");
			$finish;
		end else if (arst_n) begin
			if (out_valid && out_ready) begin
				results_n++;
				if (buzz_q.size() == 0) begin
					errors++;
					$display("%0t unexpected result: expected none actual %0b", $time, buzzer_on);
				end else if (buzzer_on !== buzz_q[0]) begin
					errors++;
					$display("%0t buzzer_on mismatch: expected %0b actual %0b",
						$time, buzz_q[0], buzzer_on);
					void'(buzz_q.pop_front());
				end else begin
					void'(buzz_q.pop_front());
				end
			end
			if (in_valid && in_ready) begin
				buzz_q.push_back(chime_step(command, now_ms, hour, minute, second));
				req_taken = 1'b1;
				accepted_n++;
			end
		end
	end

	task automatic push_req(input logic [1:0] cmd, input logic [31:0] ms,
			input logic [4:0] hr, input logic [5:0] mn, input logic [5:0] sc);
		chime_req_t r;
		r.cmd = cmd;
		r.ms = ms;
		r.hr = hr;
		r.mn = mn;
		r.sc = sc;
		pending_q.push_back(r);
		queued_n++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] d);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		case (idx)
			REG_TONE: tone_ms = d;
			REG_GAP: gap_ms = d;
			REG_BUTTON: button_ms = d;
			default: begin
			end
		endcase
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic wait_drain();
		while (accepted_n != queued_n || buzz_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (6) @(negedge clk);
	endtask

	// mostly well-formed tick streams with advancing time, plus noise
	task automatic run_random(input int unsigned n, input int unsigned step,
			input logic [31:0] start);
		int unsigned pick;
		int unsigned kind;
		logic [4:0]  hr;
		logic [5:0]  mn;
		logic [5:0]  sc;
		tb_ms = start;
		for (int unsigned i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			hr = 5'($urandom_range(0, 31));
			mn = 6'($urandom_range(0, 63));
			sc = 6'($urandom_range(0, 63));
			if (pick < 72) begin
				tb_ms += $urandom_range(0, step);
				kind = $urandom_range(0, 9);
				if (kind < 2) begin
					cur_hr = hr;
					mn = '0;
					sc = '0;
				end else if (kind == 2) begin
					mn = '0;
					sc = '0;
				end else if (kind == 3) begin
					mn = HALF_MINUTE;
					sc = '0;
				end
				if (kind == 2) begin
					hr = cur_hr;
				end
				push_req(CMD_TICK, tb_ms, hr, mn, sc);
			end else if (pick < 82) begin
				tb_ms += $urandom_range(0, step);
				push_req(CMD_BUTTON, tb_ms, hr, mn, sc);
			end else if (pick < 88) begin
				push_req(CMD_SILENCE, $urandom, hr, mn, sc);
			end else if (pick < 91) begin
				push_req(CMD_IGNORED, $urandom, hr, mn, sc);
			end else begin
				push_req(CMD_TICK, $urandom, hr, mn, sc);
			end
		end
	endtask

	initial begin
		cur_hr = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: strike, tone, button pre-emption, dial wrap, silence, wrap of time
		push_req(CMD_TICK, 32'd0, 5'd1, 6'd0, 6'd0);
		push_req(CMD_TICK, 32'd300, 5'd1, 6'd0, 6'd1);
		push_req(CMD_TICK, 32'd999, 5'd1, 6'd0, 6'd2);
		push_req(CMD_TICK, 32'd1000, 5'd1, 6'd0, 6'd3);
		push_req(CMD_TICK, 32'd1500, 5'd1, 6'd0, 6'd0);
		push_req(CMD_TICK, 32'd2000, 5'd1, HALF_MINUTE, 6'd0);
		push_req(CMD_BUTTON, 32'd2100, 5'd1, 6'd31, 6'd0);
		push_req(CMD_TICK, 32'd2220, 5'd1, 6'd31, 6'd0);
		push_req(CMD_TICK, 32'd2221, 5'd1, 6'd31, 6'd1);
		push_req(CMD_TICK, 32'd2521, 5'd1, 6'd35, 6'd0);
		push_req(CMD_TICK, 32'd2800, 5'd1, 6'd35, 6'd1);
		push_req(CMD_TICK, 32'd3000, 5'd24, 6'd0, 6'd0);
		push_req(CMD_SILENCE, 32'd3100, 5'd24, 6'd0, 6'd0);
		push_req(CMD_TICK, 32'd3200, 5'd31, 6'd0, 6'd0);
		push_req(CMD_TICK, 32'hFFFF_FFFF, 5'd23, 6'd63, 6'd63);
		push_req(CMD_TICK, 32'h0000_0100, 5'd0, 6'd0, 6'd0);
		push_req(CMD_IGNORED, 32'hFFFF_FFFF, 5'd31, 6'd63, 6'd63);
		push_req(CMD_TICK, 32'h0000_0200, 5'd0, 6'd0, 6'd59);
		push_req(CMD_BUTTON, 32'hFFFF_FFF0, 5'd0, 6'd0, 6'd0);
		push_req(CMD_TICK, 32'h0000_006F, 5'd0, 6'd0, 6'd0);
		push_req(CMD_TICK, 32'h0000_0070, 5'd0, 6'd0, 6'd0);
		push_req(CMD_SILENCE, 32'h0000_0080, 5'd0, 6'd0, 6'd0);
		push_req(CMD_TICK, 32'h0000_0090, 5'd12, HALF_MINUTE, 6'd0);
		push_req(CMD_TICK, 32'h0000_0400, 5'd12, HALF_MINUTE, 6'd0);
		wait_drain();

		// lowest settings
		write_reg(REG_TONE, 16'd1);
		write_reg(REG_GAP, 16'd1);
		write_reg(REG_BUTTON, 16'd1);
		end_writes();
		run_random(200, 4, $urandom);
		wait_drain();

		// highest settings, time wraps, long output stall
		write_reg(REG_TONE, 16'hFFFF);
		write_reg(REG_GAP, 16'hFFFF);
		write_reg(REG_BUTTON, 16'hFFFF);
		end_writes();
		run_random(200, 20000, 32'hFFFF_FFFF - $urandom_range(0, 1000000));
		repeat (5) @(negedge clk);
		hold_req = 1'b1;
		wait_drain();

		// random settings, no idling on either side
		write_reg(REG_TONE, 16'($urandom_range(1, 2000)));
		write_reg(REG_GAP, 16'($urandom_range(1, 2000)));
		write_reg(REG_BUTTON, 16'($urandom_range(1, 2000)));
		write_reg(REG_NONE, 16'($urandom));
		end_writes();
		steady = 1'b1;
		run_random(200, 800, $urandom);
		wait_drain();
		steady = 1'b0;

		// back to reset values
		write_reg(REG_BUTTON, BUTTON_RESET);
		write_reg(REG_GAP, GAP_RESET);
		write_reg(REG_TONE, TONE_RESET);
		end_writes();
		run_random(200, 500, $urandom);
		wait_drain();

		$display("run covered %0d requests and %0d results over five register settings",
			accepted_n, results_n);
		$display("predicted %0d chime tones and %0d button presses, with one long output stall",
			tones_n, presses_n);
		if (errors == 0) begin
			$display("clock_chime_beeper_unit verification clean");
		end else begin
			$display("clock_chime_beeper_unit verification failed");
		end
		$finish;
	end

endmodule

// ===== clock_chime_beeper_unit.f =====
rtl/ccb_pkg.sv
rtl/ccb_regs.sv
rtl/ccb_core.sv
rtl/clock_chime_beeper_unit.sv
tb/sv/tb_clock_chime_beeper_unit.sv
